### src/qoi_dec_pkg.sv
// Shared types and constants of the QOI stream decoder.
`default_nettype none
package qoi_dec_pkg;
   localparam int INDEX_ENTRIES_DEF    = 64;
   localparam int PIXEL_COUNT_BITS_DEF = 32;

   localparam logic [31:0] QOI_MAGIC = 32'h716F6966;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_DATA   = 2'd1;
   localparam logic [1:0] PH_SKIP   = 2'd2;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_RGB  = 2'd1;
   localparam logic [1:0] OP_RGBA = 2'd2;
   localparam logic [1:0] OP_LUMA = 2'd3;

   localparam logic [2:0] ST_DONE       = 3'd0;
   localparam logic [2:0] ST_INCOMPLETE = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC  = 3'd2;
   localparam logic [2:0] ST_BAD_CHAN   = 3'd3;
   localparam logic [2:0] ST_BAD_CSPACE = 3'd4;
   localparam logic [2:0] ST_EMPTY      = 3'd5;
   localparam logic [2:0] ST_TOO_LARGE  = 3'd6;

   localparam logic [0:0] CSR_TOTAL_BYTES = 1'd0;
   localparam logic [0:0] CSR_FOUR_CHAN   = 1'd1;

   localparam logic [7:0] BYTE_RGB  = 8'd254;
   localparam logic [7:0] BYTE_RGBA = 8'd255;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_byte;   // latch the accepted byte and process it
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;        // result pending or run in progress
   } sts_type;

   function automatic logic [5:0] hash_slot(input logic [31:0] c);
      logic [11:0] s;
      s = 12'(c[31:24]) * 12'd3 + 12'(c[23:16]) * 12'd5
        + 12'(c[15:8]) * 12'd7 + 12'(c[7:0]) * 12'd11;
      return s[5:0];
   endfunction
endpackage
`default_nettype wire

### src/qoi_dec_ctrl.sv
// Controller: accepts bytes and sequences the datapath through each one.
`default_nettype none
module qoi_dec_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire qoi_dec_pkg::sts_type sts,
   output qoi_dec_pkg::cmd_type    cmd
);
   import qoi_dec_pkg::*;

   localparam logic [0:0] S_IDLE = 1'd0;
   localparam logic [0:0] S_WORK = 1'd1;

   logic [0:0] state_ff, state_in;

   // Accept a byte only when the datapath has nothing outstanding.
   assign req_stall = (state_ff != S_IDLE) || sts.busy;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.take_byte = 1'b1;
               state_in = S_WORK;
            end
         end
         S_WORK: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

### src/qoi_dec_data.sv
// Datapath: header parsing, op decoding, colour index and result register.
`default_nettype none
module qoi_dec_data #(
   parameter int INDEX_ENTRIES    = qoi_dec_pkg::INDEX_ENTRIES_DEF,
   parameter int PIXEL_COUNT_BITS = qoi_dec_pkg::PIXEL_COUNT_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire qoi_dec_pkg::cmd_type cmd,
   output qoi_dec_pkg::sts_type      sts,
   input  wire logic [7:0]           req_stream_byte,
   input  wire logic [31:0]          total_bytes,
   input  wire logic                 four_chan,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_item_kind,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic [7:0]                rsp_alpha_out,
   output logic [2:0]                rsp_status_code,
   output logic                      rsp_last_of_run,
   output logic                      rsp_image_end
);
   import qoi_dec_pkg::*;

   localparam int IW = $clog2(INDEX_ENTRIES);

   // Architectural state.
   logic [1:0]  phase_ff;
   logic [31:0] pos_ff;
   logic [31:0] hword_ff;
   logic [31:0] width_ff, height_ff;
   logic [63:0] left_ff;
   logic [1:0]  pend_ff;
   logic [2:0]  opcnt_ff;
   logic [7:0]  luma_ff;
   logic [31:0] colour_ff;
   logic [31:0] index_mem [INDEX_ENTRIES];
   logic [INDEX_ENTRIES-1:0] ivalid_ff;

   // Step bookkeeping: a byte is latched, then processed; pixels are pushed
   // one per cycle through the output register while the receiver does not stall.
   logic        b_ff;            // byte latched, process this cycle
   logic [7:0]  v_ff;
   logic [6:0]  run_ff;          // pixels still to emit for this byte
   logic        stat_pend_ff;    // end-of-stream status still to emit
   logic [2:0]  stat_code_ff;
   logic [63:0] area_ff;
   logic [31:0] colour_pix_ff;   // colour of the pixels for the current byte
   logic [31:0] idx_q;           // index entry read when the byte is accepted
   logic        idx_ok_q;

   logic        o_valid_ff;
   logic        o_kind_ff;
   logic [23:0] o_rgb_ff;
   logic [7:0]  o_alpha_ff;
   logic [2:0]  o_status_ff;
   logic        o_last_ff;
   logic        o_end_ff;

   logic out_free;
   assign out_free = !o_valid_ff || !rsp_stall;
   assign sts.busy = b_ff || (run_ff != '0) || stat_pend_ff || o_valid_ff;

   // Registered width times height, formed as the header arrives.
   always_ff @(posedge clock) begin
      area_ff <= 64'(width_ff) * 64'(height_ff);
   end

   // Index entry named by the latched byte; unwritten entries read as zero.
   logic [31:0] idx_rd;
   assign idx_rd = idx_ok_q ? idx_q : 32'd0;

   logic [31:0] pos_v;
   logic last_b, marker_b;
   assign last_b   = (33'(pos_ff) + 33'd1) == 33'(total_bytes);
   assign marker_b = (33'(pos_ff) + 33'd8) >= 33'(total_bytes);

   // Combinational decode of the latched byte (applied only when b_ff).
   logic [31:0] hw_n, col_n;
   logic [1:0]  pend_n;
   logic [2:0]  opcnt_n;
   logic [7:0]  luma_n;
   logic        store_n;
   logic [6:0]  run_n;
   logic [63:0] left_n;
   logic [31:0] width_n, height_n;
   logic [1:0]  phase_n;
   logic        hdr_stat;
   logic [2:0]  hdr_code;
   logic        clear_idx;
   logic [7:0]  r, g, b, a, dg, ch, cs;

   always_comb begin
      r = colour_ff[31:24]; g = colour_ff[23:16];
      b = colour_ff[15:8];  a = colour_ff[7:0];
      hw_n = hword_ff; col_n = colour_ff; pend_n = pend_ff; opcnt_n = opcnt_ff;
      luma_n = luma_ff;
      store_n = 1'b0; run_n = '0; left_n = left_ff;
      width_n = width_ff; height_n = height_ff; phase_n = phase_ff;
      hdr_stat = 1'b0; hdr_code = ST_DONE; clear_idx = 1'b0;
      dg = 8'd0; ch = 8'd0; cs = 8'd0;
      pos_v = pos_ff;
      if (phase_ff == PH_HEADER) begin
         hw_n = {hword_ff[23:0], v_ff};
         ch = hw_n[15:8]; cs = hw_n[7:0];
         if (pos_v == 32'd3) begin
            left_n = 64'(hw_n);
         end else if (pos_v == 32'd7) begin
            width_n = hw_n;
         end else if (pos_v == 32'd11) begin
            height_n = hw_n;
         end else if (pos_v == 32'd13) begin
            priority if (area_ff == 64'd0) hdr_code = ST_EMPTY;
            else if (left_ff[31:0] != QOI_MAGIC) hdr_code = ST_BAD_MAGIC;
            else if (ch < 8'd3 || ch > 8'd4) hdr_code = ST_BAD_CHAN;
            else if (cs > 8'd1) hdr_code = ST_BAD_CSPACE;
            else if ((area_ff >> PIXEL_COUNT_BITS) != 64'd0) hdr_code = ST_TOO_LARGE;
            else hdr_code = ST_DONE;
            if (hdr_code != ST_DONE) begin
               hdr_stat = 1'b1;
               phase_n = PH_SKIP;
            end else begin
               phase_n = PH_DATA; left_n = area_ff; hw_n = 32'd0;
               pend_n = OP_NONE; opcnt_n = 3'd0; col_n = 32'h000000FF;
               clear_idx = 1'b1;
            end
         end
      end else if (phase_ff == PH_DATA && !marker_b) begin
         if (pend_ff != OP_NONE) begin
            hw_n = {hword_ff[23:0], v_ff};
            opcnt_n = opcnt_ff + 3'd1;
            if ((pend_ff == OP_RGB && opcnt_n == 3'd3) ||
                (pend_ff == OP_RGBA && opcnt_n == 3'd4) || pend_ff == OP_LUMA) begin
               unique case (pend_ff)
                  OP_RGB:  col_n = {hw_n[23:0], a};
                  OP_RGBA: col_n = hw_n;
                  default: begin
                     dg = {2'b00, luma_ff[5:0]} + 8'd224;
                     col_n = {r + dg + {4'd0, v_ff[7:4]} + 8'd248, g + dg,
                              b + dg + {4'd0, v_ff[3:0]} + 8'd248, a};
                  end
               endcase
               pend_n = OP_NONE; opcnt_n = 3'd0; store_n = 1'b1; run_n = 7'd1;
            end
         end else if (left_ff != 64'd0) begin
            hw_n = 32'd0; opcnt_n = 3'd0;
            if (v_ff == BYTE_RGB) begin
               pend_n = OP_RGB;
            end else if (v_ff == BYTE_RGBA) begin
               pend_n = OP_RGBA;
            end else begin
               unique case (v_ff[7:6])
                  2'b00: begin col_n = idx_rd; store_n = 1'b1; run_n = 7'd1; end
                  2'b01: begin
                     col_n = {r + {6'd0, v_ff[5:4]} + 8'd254, g + {6'd0, v_ff[3:2]} + 8'd254,
                              b + {6'd0, v_ff[1:0]} + 8'd254, a};
                     store_n = 1'b1; run_n = 7'd1;
                  end
                  2'b10: begin luma_n = v_ff; pend_n = OP_LUMA; end
                  default: begin store_n = 1'b1; run_n = {1'b0, v_ff[5:0]} + 7'd1; end
               endcase
            end
         end
      end
   end

   logic [5:0] slot_n;
   assign slot_n = hash_slot(col_n);

   // Colour index: written after a decode, read when the next byte is accepted.
   always_ff @(posedge clock) begin
      if (b_ff && store_n) begin
         index_mem[slot_n] <= col_n;
      end
      if (cmd.take_byte) begin
         idx_q    <= index_mem[req_stream_byte[IW-1:0]];
         idx_ok_q <= ivalid_ff[req_stream_byte[IW-1:0]];
      end
   end

   // State update.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; pos_ff <= '0; hword_ff <= '0;
         width_ff <= '0; height_ff <= '0; left_ff <= '0;
         pend_ff <= OP_NONE; opcnt_ff <= '0; luma_ff <= '0;
         colour_ff <= 32'h000000FF; ivalid_ff <= '0;
         b_ff <= 1'b0; run_ff <= '0; stat_pend_ff <= 1'b0; stat_code_ff <= ST_DONE;
         o_valid_ff <= 1'b0;
      end else begin
         if (cmd.take_byte) begin
            b_ff <= 1'b1;
            v_ff <= req_stream_byte;
         end
         if (b_ff) begin
            b_ff <= 1'b0;
            run_ff <= (left_n == 64'd0) ? 7'd0 : run_n;
            // Header status goes first, end status after the pixels.
            stat_pend_ff <= hdr_stat || (last_b && phase_n != PH_SKIP);
            stat_code_ff <= hdr_stat ? hdr_code :
                            (phase_n == PH_HEADER) ? ST_INCOMPLETE :
                            (left_n == 64'd0) ? ST_DONE : ST_INCOMPLETE;
            if (last_b) begin
               // The last byte never decodes, so restart for the next image now.
               phase_ff <= PH_HEADER; pos_ff <= '0; hword_ff <= '0;
               width_ff <= '0; height_ff <= '0; left_ff <= '0;
               pend_ff <= OP_NONE; opcnt_ff <= '0; luma_ff <= '0;
               colour_ff <= 32'h000000FF; ivalid_ff <= '0;
            end else begin
               hword_ff <= hw_n; colour_ff <= col_n; pend_ff <= pend_n;
               opcnt_ff <= opcnt_n; width_ff <= width_n; height_ff <= height_n;
               phase_ff <= phase_n; left_ff <= left_n; luma_ff <= luma_n;
               if (clear_idx) ivalid_ff <= '0;
               else if (store_n) ivalid_ff[slot_n] <= 1'b1;
               if (pos_ff != 32'hFFFFFFFF) pos_ff <= pos_ff + 32'd1;
            end
         end
         // Output register.
         if (out_free) begin
            o_valid_ff <= 1'b0;
            if (!b_ff && run_ff != '0 && left_ff != 64'd0) begin
               o_valid_ff  <= 1'b1;
               o_kind_ff   <= 1'b0;
               o_rgb_ff    <= colour_pix_ff[31:8];
               o_alpha_ff  <= four_chan ? 8'd255 : 8'd0;
               o_status_ff <= ST_DONE;
               o_end_ff    <= (left_ff == 64'd1);
               o_last_ff   <= (run_ff == 7'd1 || left_ff == 64'd1) && !stat_pend_ff;
               left_ff     <= left_ff - 64'd1;
               run_ff      <= (left_ff == 64'd1) ? 7'd0 : run_ff - 7'd1;
            end else if (!b_ff && stat_pend_ff) begin
               o_valid_ff  <= 1'b1;
               o_kind_ff   <= 1'b1;
               o_rgb_ff    <= '0;
               o_alpha_ff  <= '0;
               o_status_ff <= stat_code_ff;
               o_end_ff    <= 1'b0;
               o_last_ff   <= 1'b1;
               stat_pend_ff <= 1'b0;
               run_ff      <= '0;
            end
         end
      end
   end

   // Colour of the pixels emitted for the current byte.
   always_ff @(posedge clock) begin
      if (b_ff) colour_pix_ff <= col_n;
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_item_kind   = o_kind_ff;
   assign rsp_red         = o_rgb_ff[23:16];
   assign rsp_green       = o_rgb_ff[15:8];
   assign rsp_blue        = o_rgb_ff[7:0];
   assign rsp_alpha_out   = o_alpha_ff;
   assign rsp_status_code = o_status_ff;
   assign rsp_last_of_run = o_last_ff;
   assign rsp_image_end   = o_end_ff;
endmodule
`default_nettype wire

### src/qoi_image_stream_decoder.sv
// Top level of the QOI image stream decoder.
`default_nettype none
// Decodes a QOI file given one byte per transaction: the 14-byte header is
// checked, then the pixel ops are decoded and every pixel is sent as one
// result transaction, followed by a final status transaction. A byte that
// yields no result is latched, then decoded. A byte that yields results
// also holds the input while the output register is loaded and each result
// is sent, so the next byte is taken only once all are out; a run byte
// gives up to 62 pixels, and output stalls hold the input longer. Write
// total_bytes and output_four_channels only while the block is idle.
module qoi_image_stream_decoder #(
   parameter int INDEX_ENTRIES    = qoi_dec_pkg::INDEX_ENTRIES_DEF,
   parameter int PIXEL_COUNT_BITS = qoi_dec_pkg::PIXEL_COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_stream_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_item_kind,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha_out,
   output logic [2:0]       rsp_status_code,
   output logic             rsp_last_of_run,
   output logic             rsp_image_end,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import qoi_dec_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [31:0] total_bytes_ff;
   logic        four_chan_ff;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         total_bytes_ff <= '0;
         four_chan_ff   <= 1'b1;
      end else if (csr_valid) begin
         if (csr_index == CSR_TOTAL_BYTES) total_bytes_ff <= csr_data;
         else four_chan_ff <= csr_data[0];
      end
   end

   qoi_dec_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .sts, .cmd
   );

   qoi_dec_data #(
      .INDEX_ENTRIES(INDEX_ENTRIES), .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
   ) u_data (
      .clock, .reset, .cmd, .sts, .req_stream_byte,
      .total_bytes(total_bytes_ff), .four_chan(four_chan_ff),
      .rsp_valid, .rsp_stall, .rsp_item_kind, .rsp_red, .rsp_green, .rsp_blue,
      .rsp_alpha_out, .rsp_status_code, .rsp_last_of_run, .rsp_image_end
   );
endmodule
`default_nettype wire

### tb/qoi_decode_checker.sv
// Checker for the QOI stream decoder: predicts decoded pixels and status, compares them.
module qoi_decode_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_item_kind,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   input  logic [7:0]  rsp_alpha_out,
   input  logic [2:0]  rsp_status_code,
   input  logic        rsp_last_of_run,
   input  logic        rsp_image_end,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          error_count,
   output int          pending_count
);
   import qoi_dec_pkg::*;

   localparam logic [1:0] TAG_INDEX = 2'b00;
   localparam logic [1:0] TAG_DIFF  = 2'b01;
   localparam logic [1:0] TAG_LUMA  = 2'b10;
   localparam logic [1:0] TAG_RUN   = 2'b11;
   localparam logic [31:0] START_COLOUR = 32'h0000_00FF;

   typedef struct packed {
      logic       kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [2:0] status;
      logic       last;
      logic       iend;
   } decoded_item_type;

   decoded_item_type expected_items[$];

   // Configuration copy.
   logic [31:0] stream_length;
   logic        four_chan;

   // Decoder state copy.
   logic [1:0]  phase;
   logic [31:0] position;
   logic [31:0] gather_word;
   logic [31:0] img_width;
   logic [31:0] img_height;
   logic [63:0] px_left;
   logic [1:0]  pending_op;
   int          operand_cnt;
   logic [7:0]  luma_byte;
   logic [31:0] colour;
   logic [31:0] palette [64];

   assign pending_count = expected_items.size();

   function automatic logic [5:0] palette_slot(input logic [31:0] c);
      int s;
      s = c[31:24] * 3 + c[23:16] * 5 + c[15:8] * 7 + c[7:0] * 11;
      return s[5:0];
   endfunction

   task clear_image();
      phase = PH_HEADER;
      position = '0;
      gather_word = '0;
      img_width = '0;
      img_height = '0;
      px_left = '0;
      pending_op = OP_NONE;
      operand_cnt = 0;
      luma_byte = '0;
      colour = START_COLOUR;
      foreach (palette[i]) palette[i] = '0;
   endtask

   task add_pixel();
      decoded_item_type it;
      if (px_left != 0) begin
         px_left = px_left - 1;
         it = '0;
         it.red = colour[31:24];
         it.green = colour[23:16];
         it.blue = colour[15:8];
         it.alpha = four_chan ? 8'd255 : 8'd0;
         it.iend = (px_left == 0);
         expected_items.push_back(it);
      end
   endtask

   task add_status(input logic [2:0] code);
      decoded_item_type it;
      it = '0;
      it.kind = 1'b1;
      it.status = code;
      expected_items.push_back(it);
   endtask

   // One data byte of the op stream.
   task decode_op(input logic [7:0] v);
      int need;
      logic [7:0] dg, dr, db;
      if (pending_op != OP_NONE) begin
         need = (pending_op == OP_RGB) ? 3 : (pending_op == OP_RGBA) ? 4 : 1;
         gather_word = {gather_word[23:0], v};
         operand_cnt++;
         if (operand_cnt < need) return;
         if (pending_op == OP_RGB) begin
            colour = {gather_word[23:0], colour[7:0]};
         end else if (pending_op == OP_RGBA) begin
            colour = gather_word;
         end else begin
            dg = {2'b00, luma_byte[5:0]} + 8'd224;
            dr = dg + {4'd0, v[7:4]} + 8'd248;
            db = dg + {4'd0, v[3:0]} + 8'd248;
            colour = {colour[31:24] + dr, colour[23:16] + dg, colour[15:8] + db,
                      colour[7:0]};
         end
         pending_op = OP_NONE;
         operand_cnt = 0;
         palette[palette_slot(colour)] = colour;
         add_pixel();
         return;
      end
      if (px_left == 0) return;
      gather_word = '0;
      operand_cnt = 0;
      if (v == BYTE_RGB) begin
         pending_op = OP_RGB;
         return;
      end
      if (v == BYTE_RGBA) begin
         pending_op = OP_RGBA;
         return;
      end
      case (v[7:6])
         TAG_INDEX: colour = palette[v[5:0]];
         TAG_DIFF: begin
            colour = {colour[31:24] + {6'd0, v[5:4]} + 8'd254,
                      colour[23:16] + {6'd0, v[3:2]} + 8'd254,
                      colour[15:8] + {6'd0, v[1:0]} + 8'd254, colour[7:0]};
         end
         TAG_LUMA: begin
            luma_byte = v;
            pending_op = OP_LUMA;
            return;
         end
         TAG_RUN: begin
            palette[palette_slot(colour)] = colour;
            for (int k = 0; k <= v[5:0]; k++) add_pixel();
            return;
         end
      endcase
      palette[palette_slot(colour)] = colour;
      add_pixel();
   endtask

   // Whole prediction for one accepted stream byte.
   task predict_byte(input logic [7:0] v);
      int          first_new;
      logic        at_last;
      logic        in_marker;
      logic [63:0] area;
      logic [7:0]  chan, cspace;
      logic [2:0]  code;
      first_new = expected_items.size();
      at_last = ({32'd0, position} + 64'd1 == {32'd0, stream_length});
      in_marker = ({32'd0, position} + 64'd8 >= {32'd0, stream_length});
      if (phase == PH_HEADER) begin
         gather_word = {gather_word[23:0], v};
         if (position == 3) px_left = {32'd0, gather_word};
         else if (position == 7) img_width = gather_word;
         else if (position == 11) img_height = gather_word;
         else if (position == 13) begin
            area = {32'd0, img_width} * {32'd0, img_height};
            chan = gather_word[15:8];
            cspace = gather_word[7:0];
            code = ST_DONE;
            if (area == 0) code = ST_EMPTY;
            else if (px_left[31:0] != QOI_MAGIC) code = ST_BAD_MAGIC;
            else if (chan < 3 || chan > 4) code = ST_BAD_CHAN;
            else if (cspace > 1) code = ST_BAD_CSPACE;
            else if (area[63:32] != 0) code = ST_TOO_LARGE;
            if (code != ST_DONE) begin
               add_status(code);
               phase = PH_SKIP;
            end else begin
               phase = PH_DATA;
               px_left = area;
               gather_word = '0;
               pending_op = OP_NONE;
               operand_cnt = 0;
               colour = START_COLOUR;
               foreach (palette[i]) palette[i] = '0;
            end
         end
      end else if (phase == PH_DATA && !in_marker) begin
         decode_op(v);
      end
      if (at_last) begin
         if (phase == PH_HEADER) add_status(ST_INCOMPLETE);
         else if (phase == PH_DATA) add_status(px_left == 0 ? ST_DONE : ST_INCOMPLETE);
         clear_image();
      end else if (position != 32'hFFFF_FFFF) begin
         position = position + 1;
      end
      if (expected_items.size() > first_new)
         expected_items[expected_items.size() - 1].last = 1'b1;
   endtask

   task compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Watch all three channels at each rising edge.
   always @(posedge clock) begin
      decoded_item_type want;
      if (reset) begin
         stream_length = '0;
         four_chan = 1'b1;
         clear_image();
         expected_items.delete();
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TOTAL_BYTES) stream_length = csr_data;
            else four_chan = csr_data[0];
         end
         if (req_valid && !req_stall) predict_byte(req_stream_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_items.size() == 0) begin
               $display("%0t: unexpected result transaction, kind %0d status %0d",
                        $time, rsp_item_kind, rsp_status_code);
               error_count++;
            end else begin
               want = expected_items.pop_front();
               compare_field("item_kind", want.kind, rsp_item_kind);
               compare_field("red", want.red, rsp_red);
               compare_field("green", want.green, rsp_green);
               compare_field("blue", want.blue, rsp_blue);
               compare_field("alpha_out", want.alpha, rsp_alpha_out);
               compare_field("status_code", want.status, rsp_status_code);
               compare_field("last_of_run", want.last, rsp_last_of_run);
               compare_field("image_end", want.iend, rsp_image_end);
            end
         end
      end
   end
endmodule

### tb/tb.sv
// Testbench top for the QOI stream decoder: stimulus, idling and verdict.
module tb;
   import qoi_dec_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 80;
   localparam int TARGET_BYTES = 430;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_item_kind;
   logic [7:0]  rsp_red, rsp_green, rsp_blue, rsp_alpha_out;
   logic [2:0]  rsp_status_code;
   logic        rsp_last_of_run, rsp_image_end;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   int          error_count, pending_count;
   int          bytes_sent = 0;
   int          quiet_idle = 0;
   int          stall_left = 0;
   int          watchdog = 0;
   logic [7:0]  file_bytes[$];

   qoi_image_stream_decoder uut (.*);

   qoi_decode_checker checker_i (.*);

   always #10 clock = ~clock;

   // Receiver stalls: mostly short, a few long, none while quiet.
   always @(negedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if (quiet_idle || r < 65) begin
         rsp_stall = 1'b0;
      end else begin
         stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 35);
         rsp_stall = 1'b1;
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         watchdog <= 0;
      end else if (watchdog >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         watchdog <= watchdog + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task write_reg(input logic [0:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Send every queued byte, one transaction each, with sender gaps.
   task send_bytes();
      int gap;
      while (file_bytes.size() > 0) begin
         gap = pick_gap();
         @(negedge clock);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         req_valid = 1'b1;
         req_stream_byte = file_bytes.pop_front();
         do @(posedge clock); while (req_stall);
         bytes_sent++;
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task wait_drained();
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Stream the queued file with its own length as total_bytes.
   task play_file(input logic four);
      write_reg(CSR_TOTAL_BYTES, file_bytes.size());
      write_reg(CSR_FOUR_CHAN, four);
      send_bytes();
      wait_drained();
   endtask

   task push_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) file_bytes.push_back(w[i*8 +: 8]);
   endtask

   task push_header(input logic [31:0] magic, input logic [31:0] w, input logic [31:0] h,
                    input logic [7:0] chan, input logic [7:0] cspace);
      push_word(magic);
      push_word(w);
      push_word(h);
      file_bytes.push_back(chan);
      file_bytes.push_back(cspace);
   endtask

   task push_end_marker();
      repeat (7) file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h01);
   endtask

   // One random op with random content; mostly valid op kinds.
   task push_random_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         file_bytes.push_back(BYTE_RGB);
         repeat (3) file_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 22) begin
         file_bytes.push_back(BYTE_RGBA);
         repeat (4) file_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 40) begin
         file_bytes.push_back({2'b00, 6'($urandom_range(0, 63))});
      end else if (r < 60) begin
         file_bytes.push_back({2'b01, 6'($urandom_range(0, 63))});
      end else if (r < 75) begin
         file_bytes.push_back({2'b10, 6'($urandom_range(0, 63))});
         file_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 90) begin
         file_bytes.push_back({2'b11, 6'($urandom_range(0, r < 87 ? 6 : 61))});
      end else begin
         file_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // A random image: mostly small and well formed, some broken or cut short.
   task build_random_image();
      int w, h, n_ops, r, keep;
      r = $urandom_range(0, 99);
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      if (r < 8) begin
         push_header($urandom, $urandom, $urandom, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      end else if (r < 14) begin
         push_header(QOI_MAGIC, w, h, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 3)));
      end else begin
         push_header(QOI_MAGIC, w, h, 8'($urandom_range(3, 4)), 8'($urandom_range(0, 1)));
      end
      n_ops = w * h + $urandom_range(0, 4) - 2;
      for (int i = 0; i < n_ops; i++) push_random_op();
      push_end_marker();
      if ($urandom_range(0, 9) == 0) begin
         keep = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Every op kind, extreme deltas, a run cut at the image end, ignored tail.
      push_header(QOI_MAGIC, 32'd3, 32'd3, 8'd4, 8'd0);
      file_bytes.push_back(BYTE_RGB);
      file_bytes.push_back(8'hFF); file_bytes.push_back(8'h00); file_bytes.push_back(8'h80);
      file_bytes.push_back(BYTE_RGBA);
      push_word(32'h0102_0300);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h40);
      file_bytes.push_back(8'h7F);
      file_bytes.push_back(8'h80); file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hBF); file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'hFD);
      file_bytes.push_back(8'h55);
      push_end_marker();
      play_file(1'b0);

      // Header failures, each checked in its own stream.
      push_header(QOI_MAGIC, 32'hFFFF_FFFF, 32'd0, 8'd3, 8'd0);
      play_file(1'b1);
      push_header(32'h716F_6967, 32'd1, 32'd1, 8'd3, 8'd0);
      play_file(1'b1);
      push_header(QOI_MAGIC, 32'd1, 32'd1, 8'd2, 8'd0);
      play_file(1'b1);
      push_header(QOI_MAGIC, 32'd1, 32'd1, 8'd4, 8'd2);
      file_bytes.push_back(8'hC0);
      play_file(1'b1);
      push_header(QOI_MAGIC, 32'h0001_0000, 32'h0001_0000, 8'd3, 8'd1);
      play_file(1'b1);

      // Stream that ends inside the header.
      push_word(QOI_MAGIC);
      file_bytes.push_back(8'h00);
      play_file(1'b1);

      // Op left waiting for operands when the end marker begins; long run.
      push_header(QOI_MAGIC, 32'd64, 32'd1, 8'd3, 8'd0);
      file_bytes.push_back(8'hFD);
      file_bytes.push_back(BYTE_RGBA);
      file_bytes.push_back(8'h12);
      push_end_marker();
      play_file(1'b1);

      // Zero length: nothing past the header decodes; then close the stream.
      push_header(QOI_MAGIC, 32'd2, 32'd1, 8'd3, 8'd0);
      file_bytes.push_back(8'hC1);
      write_reg(CSR_TOTAL_BYTES, 32'd0);
      send_bytes();
      wait_drained();
      write_reg(CSR_TOTAL_BYTES, 32'd16);
      file_bytes.push_back(8'h00);
      send_bytes();
      wait_drained();

      // Largest length: decodes freely, then close the stream.
      push_header(QOI_MAGIC, 32'd2, 32'd2, 8'd4, 8'd1);
      file_bytes.push_back(8'hC2);
      file_bytes.push_back(8'h3F);
      write_reg(CSR_TOTAL_BYTES, 32'hFFFF_FFFF);
      send_bytes();
      wait_drained();
      write_reg(CSR_TOTAL_BYTES, 32'd17);
      file_bytes.push_back(8'h00);
      send_bytes();
      wait_drained();

      // Random images.
      while (bytes_sent < TARGET_BYTES) begin
         quiet_idle = ($urandom_range(0, 4) == 0);
         build_random_image();
         play_file(1'($urandom_range(0, 1)));
      end

      wait_drained();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
